// ----- rtl/tgl_pkg.sv -----
package tgl_pkg;

    // coordinate arithmetic width, wraps modulo 2^COORD_WIDTH (8 to 32)
    localparam int COORD_WIDTH = 16;

    typedef logic [COORD_WIDTH-1:0] t_coord;

    localparam t_coord LINE_STEP = t_coord'(13);
    localparam t_coord CHAR_STEP = t_coord'(9);

    // character codes
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [7:0] FIRST_CHAR   = 8'd32;
    localparam logic [7:0] FIRST_PRINT  = 8'd33;
    localparam logic [8:0] PRINT_END    = 9'd128;

    localparam logic [6:0] ATLAS_COLS = 7'd26;

    // configuration register addresses
    localparam logic [1:0] ADDR_FONT_READY = 2'd0;

    typedef enum logic [1:0] {
        KIND_GLYPH = 2'd0,
        KIND_COLOR = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [4:0]  cell_col;
        logic [1:0]  cell_row;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] text_height;
        logic        last;
    } t_result;

    typedef struct packed {
        t_coord cursor_x;
        t_coord cursor_y;
        t_coord start_x;
        t_coord start_y;
        logic   colors_on;
        logic   escape_pending;
        logic   in_string;
    } t_state;

    typedef struct packed {
        logic       hit;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_rgba;

    // colour escape table, fractions already scaled to 0..255
    function automatic t_rgba color_lookup(logic [7:0] code);
        t_rgba v;
        v = '{hit: 1'b1, r: 8'd255, g: 8'd255, b: 8'd255, a: 8'd255};
        case (code)
            "w", ".": v = '{1'b1, 8'd255, 8'd255, 8'd255, 8'd255};
            "W":      v = '{1'b1, 8'd179, 8'd179, 8'd179, 8'd255};
            "R":      v = '{1'b1, 8'd255, 8'd0,   8'd0,   8'd255};
            "r":      v = '{1'b1, 8'd255, 8'd179, 8'd179, 8'd255};
            "G":      v = '{1'b1, 8'd0,   8'd255, 8'd0,   8'd255};
            "g":      v = '{1'b1, 8'd179, 8'd255, 8'd179, 8'd255};
            "B":      v = '{1'b1, 8'd153, 8'd153, 8'd255, 8'd255};
            "b":      v = '{1'b1, 8'd204, 8'd204, 8'd255, 8'd255};
            "M":      v = '{1'b1, 8'd255, 8'd0,   8'd255, 8'd255};
            "m":      v = '{1'b1, 8'd255, 8'd179, 8'd255, 8'd255};
            "Y":      v = '{1'b1, 8'd255, 8'd255, 8'd0,   8'd255};
            "y":      v = '{1'b1, 8'd255, 8'd255, 8'd179, 8'd255};
            "C":      v = '{1'b1, 8'd0,   8'd255, 8'd255, 8'd255};
            "c":      v = '{1'b1, 8'd204, 8'd255, 8'd255, 8'd255};
            "O":      v = '{1'b1, 8'd255, 8'd128, 8'd0,   8'd255};
            "o":      v = '{1'b1, 8'd255, 8'd179, 8'd128, 8'd255};
            "D":      v = '{1'b1, 8'd255, 8'd255, 8'd255, 8'd128};
            "d":      v = '{1'b1, 8'd255, 8'd255, 8'd255, 8'd77};
            default:  v = '0;
        endcase
        return v;
    endfunction

    // signed 16-bit field into coordinate width
    function automatic t_coord coord_in(logic signed [15:0] v);
        logic signed [31:0] w;
        w = 32'(v);
        return w[COORD_WIDTH-1:0];
    endfunction

    // low 16 bits of a coordinate, zero filled when narrower
    function automatic logic [15:0] coord_out(t_coord v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

endpackage

// ----- rtl/tgl_ifs.sv -----
interface tgl_in_if;
    logic               valid;
    logic               ready;
    logic [7:0]         char_code;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic               color_enable;

    modport source (output valid, char_code, origin_x, origin_y, color_enable, input ready);
    modport sink   (input valid, char_code, origin_x, origin_y, color_enable, output ready);
endinterface

interface tgl_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [4:0]         cell_col;
    logic [1:0]         cell_row;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic signed [15:0] text_height;
    logic               last;

    modport source (output valid, kind, pos_x, pos_y, cell_col, cell_row, red, green, blue,
                    alpha, text_height, last, input ready);
    modport sink   (input valid, kind, pos_x, pos_y, cell_col, cell_row, red, green, blue,
                    alpha, text_height, last, output ready);
endinterface

// ----- rtl/text_glyph_layout_with_color_escapes_core.sv -----
// channel   port     dir   carries
// -------   ------   ---   ------------------------------------------------
// input     i_in     in    char_code, origin_x, origin_y, color_enable
// output    o_out    out   kind, pos_x, pos_y, cell_col, cell_row, rgba,
//                          text_height, last
// config    p*       in    font_ready at byte address 0
//
// One character is taken per cycle while the output keeps up; its words are
// in the output register the next cycle. A character giving two words (lone
// dollar before the terminator) holds the input while the second drains.
// Reset (synchronous, active low) clears the cursor, string state,
// font_ready and the output queue. A stalled output takes a new character
// only in the cycle its last pending word is taken.
module text_glyph_layout_with_color_escapes_core
    import tgl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    tgl_in_if.sink      i_in,
    tgl_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_state     r_state;
    t_state     n_state;
    logic       r_font_ready;
    t_result    r_q0;
    t_result    r_q1;
    logic [1:0] r_cnt;
    t_result    res0;
    t_result    res1;
    logic [1:0] res_cnt;
    logic       in_fire;
    logic       out_fire;
    logic       cfg_wr;

    // per-character layout step
    tgl_layout u_layout (
        .i_state        (r_state),
        .i_char         (i_in.char_code),
        .i_origin_x     (i_in.origin_x),
        .i_origin_y     (i_in.origin_y),
        .i_color_enable (i_in.color_enable),
        .i_font_ready   (r_font_ready),
        .o_state        (n_state),
        .o_res0         (res0),
        .o_res1         (res1),
        .o_count        (res_cnt)
    );

    // handshakes
    assign o_out.valid = (r_cnt != 2'd0);
    assign out_fire    = o_out.valid & o_out.ready;
    assign i_in.ready  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && o_out.ready);
    assign in_fire     = i_in.valid & i_in.ready;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr == ADDR_FONT_READY);
    assign prdata = (paddr == ADDR_FONT_READY) ? {31'd0, r_font_ready} : 32'd0;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= '0;
            r_font_ready <= 1'b0;
            r_cnt        <= 2'd0;
        end else begin
            if (cfg_wr) begin
                r_font_ready <= pwdata[0];
            end
            if (in_fire) begin
                r_state <= n_state;
                r_cnt   <= res_cnt;
            end else if (out_fire) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // output queue payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_q0 <= res0;
            r_q1 <= res1;
        end else if (out_fire) begin
            r_q0 <= r_q1;
        end
    end

    assign o_out.kind        = r_q0.kind;
    assign o_out.pos_x       = r_q0.pos_x;
    assign o_out.pos_y       = r_q0.pos_y;
    assign o_out.cell_col    = r_q0.cell_col;
    assign o_out.cell_row    = r_q0.cell_row;
    assign o_out.red         = r_q0.red;
    assign o_out.green       = r_q0.green;
    assign o_out.blue        = r_q0.blue;
    assign o_out.alpha       = r_q0.alpha;
    assign o_out.text_height = r_q0.text_height;
    assign o_out.last        = r_q0.last;

endmodule

// ----- rtl/tgl_layout.sv -----
module tgl_layout
    import tgl_pkg::*;
(
    input  t_state             i_state,
    input  logic [7:0]         i_char,
    input  logic signed [15:0] i_origin_x,
    input  logic signed [15:0] i_origin_y,
    input  logic               i_color_enable,
    input  logic               i_font_ready,
    output t_state             o_state,
    output t_result            o_res0,
    output t_result            o_res1,
    output logic [1:0]         o_count
);

    t_state     s;
    logic [7:0] glyph_code;
    logic       do_glyph;
    logic       do_color;
    logic       do_end;
    logic       glyph_emit;
    logic       color_emit;
    t_rgba      rgba;
    logic [6:0] idx;
    logic [1:0] row;
    logic [6:0] col;
    t_coord     glyph_x;
    t_coord     glyph_y;
    t_result    res_glyph;
    t_result    res_color;
    t_result    res_end;

    // cursor update and decision on which words to emit
    always_comb begin
        s = i_state;
        if (!s.in_string) begin
            s.start_x        = coord_in(i_origin_x);
            s.start_y        = coord_in(i_origin_y);
            s.cursor_x       = s.start_x;
            s.cursor_y       = s.start_y;
            s.colors_on      = i_color_enable;
            s.escape_pending = 1'b0;
            s.in_string      = 1'b1;
        end

        glyph_code = i_char;
        do_glyph   = 1'b0;
        do_color   = 1'b0;
        do_end     = 1'b0;

        if (s.escape_pending) begin
            s.escape_pending = 1'b0;
            if (i_char == CHAR_NUL) begin
                // lone dollar at end: draw it, then close the string
                glyph_code = CHAR_DOLLAR;
                do_glyph   = 1'b1;
                do_end     = 1'b1;
            end else if (i_char == CHAR_DOLLAR) begin
                glyph_code = CHAR_DOLLAR;
                do_glyph   = 1'b1;
            end else begin
                do_color = 1'b1;
            end
        end else begin
            case (i_char)
                CHAR_NUL: begin
                    do_end = 1'b1;
                end
                CHAR_NEWLINE: begin
                    s.cursor_x = s.start_x;
                    s.cursor_y = s.cursor_y + LINE_STEP;
                end
                CHAR_SPACE: begin
                    s.cursor_x = s.cursor_x + CHAR_STEP;
                end
                CHAR_DOLLAR: begin
                    s.escape_pending = 1'b1;
                end
                default: begin
                    if (i_char >= FIRST_PRINT && {1'b0, i_char} < PRINT_END) begin
                        do_glyph = 1'b1;
                    end
                end
            endcase
        end

        // glyph sits at the cursor before it advances
        glyph_x = s.cursor_x;
        glyph_y = s.cursor_y;
        if (do_glyph) begin
            s.cursor_x = s.cursor_x + CHAR_STEP;
        end
        if (do_end) begin
            s.in_string      = 1'b0;
            s.escape_pending = 1'b0;
        end
        o_state = s;
    end

    // atlas cell: row by compares, column by subtraction
    always_comb begin
        idx = 7'(glyph_code - FIRST_CHAR);
        if (idx >= 7'(3 * ATLAS_COLS)) begin
            row = 2'd3;
        end else if (idx >= 7'(2 * ATLAS_COLS)) begin
            row = 2'd2;
        end else if (idx >= ATLAS_COLS) begin
            row = 2'd1;
        end else begin
            row = 2'd0;
        end
        col = idx - 7'(row * ATLAS_COLS);
    end

    assign rgba       = color_lookup(i_char);
    assign glyph_emit = do_glyph & i_font_ready;
    assign color_emit = do_color & rgba.hit & s.colors_on & i_font_ready;

    // result words, unused fields zero
    always_comb begin
        res_glyph          = '0;
        res_glyph.kind     = KIND_GLYPH;
        res_glyph.pos_x    = coord_out(glyph_x);
        res_glyph.pos_y    = coord_out(glyph_y);
        res_glyph.cell_col = col[4:0];
        res_glyph.cell_row = row;

        res_color       = '0;
        res_color.kind  = KIND_COLOR;
        res_color.red   = rgba.r;
        res_color.green = rgba.g;
        res_color.blue  = rgba.b;
        res_color.alpha = rgba.a;

        res_end      = '0;
        res_end.kind = KIND_END;
        res_end.last = 1'b1;
        if (i_font_ready) begin
            res_end.text_height = coord_out(s.cursor_y + LINE_STEP - s.start_y);
        end
    end

    // ordering: glyph first, then colour or end
    always_comb begin
        o_count = 2'(glyph_emit) + 2'(color_emit) + 2'(do_end);
        if (glyph_emit) begin
            o_res0 = res_glyph;
        end else if (color_emit) begin
            o_res0 = res_color;
        end else begin
            o_res0 = res_end;
        end
        o_res0.last = (o_count == 2'd1);
        o_res1      = res_end;
    end

endmodule

// ----- tb/tb.sv -----
module tb;
    import tgl_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tgl_in_if  in_if ();
    tgl_out_if out_if ();

    text_glyph_layout_with_color_escapes_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // layout prediction state
    t_coord cur_x, cur_y, org_x, org_y;
    logic   colours_on, dollar_seen, in_text;
    logic   font_on;

    // words predicted for the character in hand, then words still owed by the block
    t_result batch[$];
    t_result due_words[$];
    t_result want;

    // origin and colour enable of the string being sent
    logic signed [15:0] str_ox, str_oy;
    logic               str_ce;

    int send_idle_pct;
    int stall_pct;
    int mismatches;
    int n_sent;
    int n_glyph, n_colour, n_end;

    always #4 i_clk = ~i_clk;

    // rgba of a colour code, top bit set when the code is known
    function automatic logic [32:0] colour_of(logic [7:0] code);
        case (code)
            "w", ".": return {1'b1, 8'd255, 8'd255, 8'd255, 8'd255};
            "W":      return {1'b1, 8'd179, 8'd179, 8'd179, 8'd255};
            "R":      return {1'b1, 8'd255, 8'd0,   8'd0,   8'd255};
            "r":      return {1'b1, 8'd255, 8'd179, 8'd179, 8'd255};
            "G":      return {1'b1, 8'd0,   8'd255, 8'd0,   8'd255};
            "g":      return {1'b1, 8'd179, 8'd255, 8'd179, 8'd255};
            "B":      return {1'b1, 8'd153, 8'd153, 8'd255, 8'd255};
            "b":      return {1'b1, 8'd204, 8'd204, 8'd255, 8'd255};
            "M":      return {1'b1, 8'd255, 8'd0,   8'd255, 8'd255};
            "m":      return {1'b1, 8'd255, 8'd179, 8'd255, 8'd255};
            "Y":      return {1'b1, 8'd255, 8'd255, 8'd0,   8'd255};
            "y":      return {1'b1, 8'd255, 8'd255, 8'd179, 8'd255};
            "C":      return {1'b1, 8'd0,   8'd255, 8'd255, 8'd255};
            "c":      return {1'b1, 8'd204, 8'd255, 8'd255, 8'd255};
            "O":      return {1'b1, 8'd255, 8'd128, 8'd0,   8'd255};
            "o":      return {1'b1, 8'd255, 8'd179, 8'd128, 8'd255};
            "D":      return {1'b1, 8'd255, 8'd255, 8'd255, 8'd128};
            "d":      return {1'b1, 8'd255, 8'd255, 8'd255, 8'd77};
            default:  return '0;
        endcase
    endfunction

    // glyph quad at the cursor, cursor steps right even with the font off
    task automatic emit_glyph(input logic [7:0] c);
        t_result w;
        int      idx;
        idx = int'(c) - int'(FIRST_CHAR);
        if (font_on) begin
            w          = '0;
            w.kind     = KIND_GLYPH;
            w.pos_x    = 16'(cur_x);
            w.pos_y    = 16'(cur_y);
            w.cell_col = 5'(idx % int'(ATLAS_COLS));
            w.cell_row = 2'(idx / int'(ATLAS_COLS));
            batch.push_back(w);
        end
        cur_x = cur_x + CHAR_STEP;
    endtask

    task automatic emit_colour(input logic [7:0] code);
        t_result     w;
        logic [32:0] rgba;
        rgba = colour_of(code);
        if (colours_on && font_on && rgba[32]) begin
            w       = '0;
            w.kind  = KIND_COLOR;
            w.red   = rgba[31:24];
            w.green = rgba[23:16];
            w.blue  = rgba[15:8];
            w.alpha = rgba[7:0];
            batch.push_back(w);
        end
    endtask

    task automatic emit_end();
        t_result w;
        w      = '0;
        w.kind = KIND_END;
        if (font_on)
            w.text_height = 16'(t_coord'(cur_y + LINE_STEP - org_y));
        batch.push_back(w);
        in_text     = 1'b0;
        dollar_seen = 1'b0;
    endtask

    // advance the layout by one accepted character and queue its words
    task automatic layout_char(input logic [7:0] c, input logic signed [15:0] ox,
                               input logic signed [15:0] oy, input logic ce);
        t_result w;
        batch.delete();
        if (!in_text) begin
            org_x       = t_coord'(int'(ox));
            org_y       = t_coord'(int'(oy));
            colours_on  = ce;
            cur_x       = org_x;
            cur_y       = org_y;
            dollar_seen = 1'b0;
            in_text     = 1'b1;
        end
        if (dollar_seen) begin
            dollar_seen = 1'b0;
            if (c == CHAR_NUL) begin
                emit_glyph(CHAR_DOLLAR);
                emit_end();
            end else if (c == CHAR_DOLLAR) begin
                emit_glyph(CHAR_DOLLAR);
            end else begin
                emit_colour(c);
            end
        end else if (c == CHAR_NUL) begin
            emit_end();
        end else if (c == CHAR_NEWLINE) begin
            cur_x = org_x;
            cur_y = cur_y + LINE_STEP;
        end else if (c == CHAR_SPACE) begin
            cur_x = cur_x + CHAR_STEP;
        end else if (c == CHAR_DOLLAR) begin
            dollar_seen = 1'b1;
        end else if (c >= FIRST_PRINT && 9'(c) < PRINT_END) begin
            emit_glyph(c);
        end
        if (batch.size() != 0) begin
            w      = batch.pop_back();
            w.last = 1'b1;
            batch.push_back(w);
        end
        while (batch.size() != 0)
            due_words.push_back(batch.pop_front());
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 20)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (got_v !== exp_v)
            report_mismatch($sformatf("%s expected %0h got %0h", name, exp_v, got_v));
    endtask

    // output side: random stalls and word checking
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (due_words.size() == 0) begin
                report_mismatch("word with nothing expected");
            end else begin
                want = due_words.pop_front();
                case (want.kind)
                    KIND_GLYPH: n_glyph++;
                    KIND_COLOR: n_colour++;
                    default:    n_end++;
                endcase
                check_field("kind", 16'(want.kind), 16'(out_if.kind));
                check_field("pos_x", want.pos_x, out_if.pos_x);
                check_field("pos_y", want.pos_y, out_if.pos_y);
                check_field("cell_col", 16'(want.cell_col), 16'(out_if.cell_col));
                check_field("cell_row", 16'(want.cell_row), 16'(out_if.cell_row));
                check_field("red", 16'(want.red), 16'(out_if.red));
                check_field("green", 16'(want.green), 16'(out_if.green));
                check_field("blue", 16'(want.blue), 16'(out_if.blue));
                check_field("alpha", 16'(want.alpha), 16'(out_if.alpha));
                check_field("text_height", want.text_height, out_if.text_height);
                check_field("last", 16'(want.last), 16'(out_if.last));
            end
        end
        out_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // one character, origin fields only meaningful on the first of a string
    task automatic put_char(input logic [7:0] c);
        logic signed [15:0] ox, oy;
        logic               ce;
        if (!in_text) begin
            ox = str_ox;
            oy = str_oy;
            ce = str_ce;
        end else begin
            ox = 16'($urandom);
            oy = 16'($urandom);
            ce = 1'($urandom_range(1));
        end
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.char_code    <= c;
        in_if.origin_x     <= ox;
        in_if.origin_y     <= oy;
        in_if.color_enable <= ce;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        layout_char(c, ox, oy, ce);
        n_sent++;
    endtask

    // stop sending and let every owed word drain
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_font_ready(input logic v);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FONT_READY;
        pwdata  <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        font_on = v;
    endtask

    function automatic logic signed [15:0] pick_coord();
        if ($urandom_range(99) < 15) begin
            case ($urandom_range(3))
                0:       return 16'sh8000;
                1:       return 16'sh7fff;
                2:       return 16'sh0000;
                default: return -16'sd1;
            endcase
        end
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] pick_code();
        string codes;
        int    sel;
        codes = "wWRrGgBbMmYyCcOoDd.";
        sel   = $urandom_range(99);
        if (sel < 70)
            return codes[$urandom_range(18)];
        else if (sel < 80)
            return CHAR_DOLLAR;
        return 8'($urandom_range(255, 1));
    endfunction

    // font still off after reset: cursor moves, only a zero height comes out
    task automatic test_font_off_at_reset();
        str_ox = 16'sd100;
        str_oy = -16'sd50;
        str_ce = 1'b1;
        put_char("A");
        put_char(CHAR_DOLLAR);
        put_char("R");
        put_char(CHAR_NUL);
    endtask

    // an empty string and a full one at the extreme origins, every character class and escape kind
    task automatic test_edge_strings();
        write_font_ready(1'b1);
        str_ox = 16'sh7fff;
        str_oy = 16'sh8000;
        str_ce = 1'b1;
        put_char(CHAR_NUL);
        str_ox = 16'sh8000;
        str_oy = 16'sh7fff;
        put_char(FIRST_PRINT);
        put_char(8'd127);
        put_char(8'd128);
        put_char(8'd255);
        put_char(8'd1);
        put_char(8'd31);
        put_char(CHAR_SPACE);
        put_char(CHAR_NEWLINE);
        put_char(CHAR_DOLLAR);
        put_char(CHAR_DOLLAR);
        put_char(CHAR_DOLLAR);
        put_char("R");
        put_char(CHAR_DOLLAR);
        put_char("Z");
        put_char(CHAR_DOLLAR);
        put_char(CHAR_NEWLINE);
        put_char(CHAR_DOLLAR);
        put_char("d");
        // lone dollar before the terminator
        put_char(CHAR_DOLLAR);
        put_char(CHAR_NUL);
    endtask

    // colour escape with colours disabled for the string
    task automatic test_colour_disabled();
        str_ox = 16'sd0;
        str_oy = 16'sd0;
        str_ce = 1'b0;
        put_char(CHAR_DOLLAR);
        put_char("G");
        put_char(CHAR_NUL);
    endtask

    // mostly well-formed strings with random content, some noise and runaway strings
    task automatic test_random_strings(input int count, input int sp, input int rp);
        int goal;
        int len;
        int sel;
        goal          = n_sent + count;
        send_idle_pct = sp;
        stall_pct     = rp;
        while (n_sent < goal) begin
            str_ox = pick_coord();
            str_oy = pick_coord();
            str_ce = 1'($urandom_range(1));
            len    = ($urandom_range(99) < 85) ? $urandom_range(10) : $urandom_range(40);
            repeat (len) begin
                sel = $urandom_range(99);
                if (sel < 45) begin
                    put_char(8'($urandom_range(127, 33)));
                end else if (sel < 55) begin
                    put_char(CHAR_SPACE);
                end else if (sel < 63) begin
                    put_char(CHAR_NEWLINE);
                end else if (sel < 82) begin
                    put_char(CHAR_DOLLAR);
                    put_char(pick_code());
                end else if (sel < 91) begin
                    put_char(8'($urandom_range(31, 1)));
                end else begin
                    put_char(8'($urandom_range(255, 128)));
                end
            end
            sel = $urandom_range(99);
            if (sel < 10) begin
                put_char(CHAR_DOLLAR);
                put_char(CHAR_NUL);
            end else if (sel < 94) begin
                put_char(CHAR_NUL);
            end
        end
    endtask

    // run length limit
    initial begin
        #2000000;
        $display("** text_glyph_layout_with_color_escapes_core: FAILED **");
        $finish;
    end

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_if.valid        = 1'b0;
        in_if.char_code    = '0;
        in_if.origin_x     = '0;
        in_if.origin_y     = '0;
        in_if.color_enable = 1'b0;
        out_if.ready       = 1'b0;
        cur_x              = '0;
        cur_y              = '0;
        org_x              = '0;
        org_y              = '0;
        colours_on         = 1'b0;
        dollar_seen        = 1'b0;
        in_text            = 1'b0;
        font_on            = 1'b0;
        send_idle_pct      = 0;
        stall_pct          = 0;
        mismatches         = 0;
        n_sent             = 0;
        n_glyph            = 0;
        n_colour           = 0;
        n_end              = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_font_off_at_reset();
        test_edge_strings();
        test_colour_disabled();
        test_random_strings(500, 0, 0);
        test_random_strings(450, 88, 0);
        write_font_ready(1'b0);
        test_random_strings(350, 0, 88);
        write_font_ready(1'b1);
        test_random_strings(300, 9, 9);
        // sender holds off until the block has nothing left to deliver
        wait_idle();
        test_random_strings(300, 9, 9);

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("%0d characters sent: font off and on, extreme origins, escapes, noise,",
                 n_sent);
        $display("four idling mixes; %0d glyph, %0d colour, %0d end words checked",
                 n_glyph, n_colour, n_end);
        if (mismatches == 0) begin
            $display("** text_glyph_layout_with_color_escapes_core: PASSED **");
        end else begin
            $display("** text_glyph_layout_with_color_escapes_core: FAILED **");
        end
        $finish;
    end

endmodule
